/* hw/rtl/pitch_peak_interval_merge_unit_macros.svh */
// Assertion macros shared by the pitch peak interval merge RTL.
`ifndef PITCH_PEAK_INTERVAL_MERGE_UNIT_MACROS_SVH
`define PITCH_PEAK_INTERVAL_MERGE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PPIM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppim assertion failed");
// Next-cycle implication, checked outside reset.
`define PPIM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppim assertion failed");
`else
`define PPIM_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PPIM_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/ppim_pkg.sv */
package ppim_pkg;

  localparam int unsigned PitchW  = 16;
  localparam int unsigned VolW    = 16;
  localparam int unsigned VsumW   = 24;
  localparam int unsigned WsumW   = 40;
  localparam int unsigned DivSteps = PitchW;

  // configuration register indexes
  localparam logic [1:0] REG_MERGE_DISTANCE = 2'd0;
  localparam logic [1:0] REG_PITCH_MODE     = 2'd1;
  localparam logic [1:0] REG_VOLUME_MODE    = 2'd2;
  localparam logic [1:0] REG_VOLUME_FLOOR   = 2'd3;

  // pitch reduction modes; the unused code acts as the center
  localparam logic [1:0] PITCH_CENTER  = 2'd0;
  localparam logic [1:0] PITCH_LOUDEST = 2'd1;
  localparam logic [1:0] PITCH_MEAN    = 2'd2;

  localparam logic VOLUME_MAX = 1'b0;
  localparam logic VOLUME_SUM = 1'b1;

  localparam logic [15:0] RESET_MERGE_DISTANCE = 16'd1536;
  localparam logic [1:0]  RESET_PITCH_MODE     = PITCH_CENTER;
  localparam logic        RESET_VOLUME_MODE    = VOLUME_SUM;
  localparam logic [23:0] RESET_VOLUME_FLOOR   = 24'd0;

  typedef struct packed {
    logic              start;
    logic [WsumW-1:0]  dividend;
    logic [VsumW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PitchW-1:0] quotient;
  } div_rsp_t;

endpackage

/* hw/rtl/pitch_peak_interval_merge_unit.sv */
// Pitch peak interval merge.
// Input channel: one peak per transaction (pitch Q7.9, volume Q1.15, frame_last),
// accepted when in_valid_i is high and in_stall_o is low. Peaks of a frame
// arrive sorted by pitch; peaks share one interval while its spread stays within merge_distance.
// Output channel: reduced intervals (pitch, volume, has_pitch, frame_end),
// taken when out_valid_o is high and out_stall_i is low; at most two per peak.
// A peak that merges into the open interval passes through CHECK, one that opens an
// interval through CHECK and OPEN. Closing an interval adds REDUCE and LOAD, with
// the serial divider (ST_DIV) between them in the weighted mean mode, and a frame's
// last peak that also splits an interval closes two intervals.
// The divider produces one quotient bit per cycle.
// The input stalls (in_stall_o high) while a peak is in work. A finished result
// moves to an output register, so the next peak is accepted while it waits; a
// further result that finds the register full holds the block until it drains.
// Results stay stable while out_stall_i is high.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i); the user
// writes it only while the block is idle, which the block itself does not enforce.
// Reset restores the register defaults and closes any open interval.
module pitch_peak_interval_merge_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] peak_pitch_i,
  input  logic [15:0] peak_volume_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_pitch_o,
  output logic [23:0] out_volume_o,
  output logic        has_pitch_o,
  output logic        frame_end_o
);

`include "pitch_peak_interval_merge_unit_macros.svh"

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_REDUCE = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_LOAD   = 3'd4;
  localparam logic [2:0] ST_OPEN   = 3'd5;

  localparam int unsigned PW = ppim_pkg::PitchW;
  localparam int unsigned VW = ppim_pkg::VolW;
  localparam int unsigned SW = ppim_pkg::VsumW;
  localparam int unsigned WW = ppim_pkg::WsumW;

  logic [2:0]    state_q, state_d;

  logic [15:0]   merge_distance_q;
  logic [1:0]    pitch_mode_q;
  logic          volume_mode_q;
  logic [23:0]   volume_floor_q;

  logic [PW-1:0]    peak_pitch_q;
  logic [VW-1:0]    peak_volume_q;
  logic             last_q;
  logic [PW+VW-1:0] prod_q;

  logic          open_q, open_d;
  logic [PW-1:0] low_q, low_d;
  logic [PW-1:0] high_q, high_d;
  logic [PW-1:0] loud_pitch_q, loud_pitch_d;
  logic [VW-1:0] loud_vol_q, loud_vol_d;
  logic [SW-1:0] vsum_q, vsum_d;
  logic [WW-1:0] wsum_q, wsum_d;

  logic          end_q, end_d;
  logic          keep_q, keep_d;
  logic [PW-1:0] red_pitch_q, red_pitch_d;
  logic [SW-1:0] red_vol_q, red_vol_d;

  logic          out_valid_q;
  logic [PW-1:0] out_pitch_q;
  logic [SW-1:0] out_vol_q;
  logic          out_has_q;
  logic          out_end_q;

  logic          in_accept;
  logic          out_take;
  logic          slot_free;
  logic          out_load;

  logic [PW-1:0] lo_c, hi_c, spread;
  logic [SW:0]   vsum_add;
  logic [WW:0]   wsum_add;
  logic [SW-1:0] vol_c;
  logic [PW:0]   center;

  ppim_pkg::div_req_t div_req;
  ppim_pkg::div_rsp_t div_rsp;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != ST_IDLE;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_distance_q <= ppim_pkg::RESET_MERGE_DISTANCE;
      pitch_mode_q     <= ppim_pkg::RESET_PITCH_MODE;
      volume_mode_q    <= ppim_pkg::RESET_VOLUME_MODE;
      volume_floor_q   <= ppim_pkg::RESET_VOLUME_FLOOR;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ppim_pkg::REG_MERGE_DISTANCE: merge_distance_q <= cfg_wdata_i[15:0];
        ppim_pkg::REG_PITCH_MODE:     pitch_mode_q     <= cfg_wdata_i[1:0];
        ppim_pkg::REG_VOLUME_MODE:    volume_mode_q    <= cfg_wdata_i[0];
        ppim_pkg::REG_VOLUME_FLOOR:   volume_floor_q   <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // capture the peak and its pitch-volume product
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      peak_pitch_q  <= peak_pitch_i;
      peak_volume_q <= peak_volume_i;
      last_q        <= frame_last_i;
      prod_q        <= peak_pitch_i * peak_volume_i;
    end
  end

  assign lo_c     = (low_q < peak_pitch_q) ? low_q : peak_pitch_q;
  assign hi_c     = (high_q > peak_pitch_q) ? high_q : peak_pitch_q;
  assign spread   = hi_c - lo_c;
  assign vsum_add = {1'b0, vsum_q} + {(SW + 1 - VW)'(0), peak_volume_q};
  assign wsum_add = {1'b0, wsum_q} + {(WW + 1 - PW - VW)'(0), prod_q};
  assign vol_c    = (volume_mode_q == ppim_pkg::VOLUME_SUM) ? vsum_q
                                                            : {(SW - VW)'(0), loud_vol_q};
  assign center   = ({1'b0, low_q} + {1'b0, high_q}) >> 1;

  always_comb begin
    state_d      = state_q;
    open_d       = open_q;
    low_d        = low_q;
    high_d       = high_q;
    loud_pitch_d = loud_pitch_q;
    loud_vol_d   = loud_vol_q;
    vsum_d       = vsum_q;
    wsum_d       = wsum_q;
    end_d        = end_q;
    keep_d       = keep_q;
    red_pitch_d  = red_pitch_q;
    red_vol_d    = red_vol_q;
    div_req.start    = 1'b0;
    div_req.dividend = wsum_q;
    div_req.divisor  = vsum_q;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (open_q && (spread > merge_distance_q)) begin
          end_d   = 1'b0;
          state_d = ST_REDUCE;
        end else begin
          if (open_q) begin
            low_d  = lo_c;
            high_d = hi_c;
            vsum_d = vsum_add[SW] ? '1 : vsum_add[SW-1:0];
            wsum_d = wsum_add[WW] ? '1 : wsum_add[WW-1:0];
            if (loud_vol_q < peak_volume_q) begin
              loud_vol_d   = peak_volume_q;
              loud_pitch_d = peak_pitch_q;
            end
            state_d = last_q ? ST_REDUCE : ST_IDLE;
            end_d   = last_q;
          end else begin
            state_d = ST_OPEN;
          end
        end
      end
      ST_OPEN: begin
        open_d       = 1'b1;
        low_d        = peak_pitch_q;
        high_d       = peak_pitch_q;
        loud_pitch_d = peak_pitch_q;
        loud_vol_d   = peak_volume_q;
        vsum_d       = {(SW - VW)'(0), peak_volume_q};
        wsum_d       = {(WW - PW - VW)'(0), prod_q};
        end_d        = last_q;
        state_d      = last_q ? ST_REDUCE : ST_IDLE;
      end
      ST_REDUCE: begin
        open_d    = 1'b0;
        red_vol_d = vol_c;
        keep_d    = vol_c >= volume_floor_q;
        state_d   = ST_LOAD;
        case (pitch_mode_q)
          ppim_pkg::PITCH_LOUDEST: red_pitch_d = loud_pitch_q;
          ppim_pkg::PITCH_MEAN: begin
            if (vsum_q == '0) begin
              red_pitch_d = low_q;
            end else begin
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end
          end
          default: red_pitch_d = center[PW-1:0];
        endcase
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          red_pitch_d = div_rsp.quotient;
          state_d     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!keep_q && !end_q) begin
          // drop a quiet interval closed by the spread rule
          state_d = ST_OPEN;
        end else if (slot_free) begin
          out_load = 1'b1;
          state_d  = end_q ? ST_IDLE : ST_OPEN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      open_q       <= 1'b0;
      low_q        <= '0;
      high_q       <= '0;
      loud_pitch_q <= '0;
      loud_vol_q   <= '0;
      vsum_q       <= '0;
      wsum_q       <= '0;
      end_q        <= 1'b0;
      keep_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      open_q       <= open_d;
      low_q        <= low_d;
      high_q       <= high_d;
      loud_pitch_q <= loud_pitch_d;
      loud_vol_q   <= loud_vol_d;
      vsum_q       <= vsum_d;
      wsum_q       <= wsum_d;
      end_q        <= end_d;
      keep_q       <= keep_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    red_pitch_q <= red_pitch_d;
    red_vol_q   <= red_vol_d;
    if (out_load) begin
      out_end_q <= end_q;
      out_has_q <= keep_q;
      // an end marker for a dropped flush carries no pitch and no volume
      out_pitch_q <= keep_q ? red_pitch_q : '0;
      out_vol_q   <= keep_q ? red_vol_q : '0;
    end
  end

  ppim_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o  = out_valid_q;
  assign out_pitch_o  = out_pitch_q;
  assign out_volume_o = out_vol_q;
  assign has_pitch_o  = out_has_q;
  assign frame_end_o  = out_end_q;

  `PPIM_ASSERT_IMP(a_div_done_in_div, clk_i, rst_ni, div_rsp.done, state_q == ST_DIV)
  `PPIM_ASSERT_NXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `PPIM_ASSERT_NXT(a_flush_closes, clk_i, rst_ni, out_load && end_q, !open_q)
  `PPIM_ASSERT_IMP(a_marker_empty, clk_i, rst_ni, out_valid_o && !has_pitch_o,
                   frame_end_o && (out_pitch_o == '0) && (out_volume_o == '0))

endmodule

/* hw/rtl/ppim_div.sv */
// Restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
module ppim_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppim_pkg::div_req_t req_i,
  output ppim_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(ppim_pkg::DivSteps);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic [ppim_pkg::VsumW-1:0]     rem_q, rem_d;
  logic [ppim_pkg::PitchW-1:0]    quo_q, quo_d;
  logic [ppim_pkg::VsumW:0]       trial;
  logic [ppim_pkg::VsumW:0]       diff;
  logic                           sat;

  // quotient overflows 16 bits exactly when the upper dividend bits reach the divisor
  assign sat   = req_i.dividend[ppim_pkg::WsumW-1:ppim_pkg::PitchW] >= req_i.divisor;
  assign trial = {rem_q, quo_q[ppim_pkg::PitchW-1]};
  assign diff  = trial - {1'b0, req_i.divisor};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      cnt_d = '0;
      rem_d = req_i.dividend[ppim_pkg::WsumW-1:ppim_pkg::PitchW];
      if (sat) begin
        quo_d  = '1;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        quo_d  = req_i.dividend[ppim_pkg::PitchW-1:0];
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      // shift dividend bits out the top, quotient bits in at the bottom
      if (trial >= {1'b0, req_i.divisor}) begin
        rem_d = diff[ppim_pkg::VsumW-1:0];
        quo_d = {quo_q[ppim_pkg::PitchW-2:0], 1'b1};
      end else begin
        rem_d = trial[ppim_pkg::VsumW-1:0];
        quo_d = {quo_q[ppim_pkg::PitchW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ppim_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* test/tb_pitch_peak_interval_merge_unit.sv */
module tb_pitch_peak_interval_merge_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] PITCH_UNUSED = 2'd3;
  localparam int CycleLimit  = 500000;
  localparam int SettleCycles = 60;
  localparam int MaxReports  = 10;

  typedef struct packed {
    logic [15:0] pitch;
    logic [23:0] volume;
    logic        has_pitch;
    logic        frame_end;
  } interval_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = ppim_pkg::REG_MERGE_DISTANCE;
  logic [23:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] peak_pitch_i = '0;
  logic [15:0] peak_volume_i = '0;
  logic        frame_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] out_pitch_o;
  logic [23:0] out_volume_o;
  logic        has_pitch_o;
  logic        frame_end_o;

  pitch_peak_interval_merge_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .peak_pitch_i  (peak_pitch_i),
    .peak_volume_i (peak_volume_i),
    .frame_last_i  (frame_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_pitch_o   (out_pitch_o),
    .out_volume_o  (out_volume_o),
    .has_pitch_o   (has_pitch_o),
    .frame_end_o   (frame_end_o)
  );

  always #2 clk_i = ~clk_i;

  // interval merge state mirrored by the testbench
  logic        iv_open;
  logic [15:0] iv_low;
  logic [15:0] iv_high;
  logic [15:0] iv_loud_pitch;
  logic [15:0] iv_loud_vol;
  logic [23:0] iv_vol_sum;
  logic [39:0] iv_weighted_sum;
  logic [15:0] cfg_distance;
  logic [1:0]  cfg_pitch_mode;
  logic        cfg_volume_mode;
  logic [23:0] cfg_floor;

  interval_t pending_intervals[$];
  int        err_count = 0;
  int        cycle_count = 0;
  bit        in_gaps_on = 1'b1;
  bit        out_stalls_on = 1'b1;
  int        stall_run = 0;
  bit        stall_now = 1'b0;

  function automatic int pick_run_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // append one predicted result to the queue
  task automatic want_interval(logic [15:0] p, logic [23:0] v, logic has, logic fe);
    interval_t item;
    item.pitch     = p;
    item.volume    = v;
    item.has_pitch = has;
    item.frame_end = fe;
    pending_intervals.insert(pending_intervals.size(), item);
  endtask

  task automatic add_to_interval(logic [15:0] p, logic [15:0] v);
    logic [24:0] vs;
    logic [40:0] ws;
    vs = iv_vol_sum + v;
    iv_vol_sum = vs[24] ? 24'hFF_FFFF : vs[23:0];
    ws = iv_weighted_sum + p * v;
    iv_weighted_sum = ws[40] ? 40'hFF_FFFF_FFFF : ws[39:0];
    if (iv_loud_vol < v) begin
      iv_loud_vol = v;
      iv_loud_pitch = p;
    end
  endtask

  task automatic close_interval(output logic [15:0] rp, output logic [23:0] rv,
                                output logic keep);
    logic [39:0] quot;
    logic [16:0] mid;
    rv = (cfg_volume_mode == ppim_pkg::VOLUME_SUM) ? iv_vol_sum : {8'd0, iv_loud_vol};
    case (cfg_pitch_mode)
      ppim_pkg::PITCH_LOUDEST: rp = iv_loud_pitch;
      ppim_pkg::PITCH_MEAN: begin
        if (iv_vol_sum == 0) begin
          rp = iv_low;
        end else begin
          quot = iv_weighted_sum / iv_vol_sum;
          rp = (quot > 40'hFFFF) ? 16'hFFFF : quot[15:0];
        end
      end
      default: begin
        mid = {1'b0, iv_low} + iv_high;
        rp = mid[16:1];
      end
    endcase
    iv_open = 1'b0;
    keep = (rv >= cfg_floor);
  endtask

  task automatic merge_peak(logic [15:0] p, logic [15:0] v, logic last);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] rp;
    logic [23:0] rv;
    logic        keep;
    if (iv_open) begin
      lo = (iv_low < p) ? iv_low : p;
      hi = (iv_high > p) ? iv_high : p;
      if (hi - lo > cfg_distance) begin
        close_interval(rp, rv, keep);
        if (keep) want_interval(rp, rv, 1'b1, 1'b0);
      end else begin
        iv_low = lo;
        iv_high = hi;
        add_to_interval(p, v);
      end
    end
    if (!iv_open) begin
      iv_open = 1'b1;
      iv_low = p;
      iv_high = p;
      iv_loud_pitch = p;
      iv_loud_vol = '0;
      iv_vol_sum = '0;
      iv_weighted_sum = '0;
      add_to_interval(p, v);
    end
    if (last) begin
      close_interval(rp, rv, keep);
      if (keep) want_interval(rp, rv, 1'b1, 1'b1);
      else want_interval(16'd0, 24'd0, 1'b0, 1'b1);
    end
  endtask

  task automatic check_interval();
    interval_t want;
    if (pending_intervals.size() == 0) begin
      if (err_count < MaxReports)
        $display("unexpected result: pitch %0d volume %0d has_pitch %0b frame_end %0b",
                 out_pitch_o, out_volume_o, has_pitch_o, frame_end_o);
      err_count++;
    end else begin
      want = pending_intervals.pop_front();
      if (out_pitch_o !== want.pitch || out_volume_o !== want.volume ||
          has_pitch_o !== want.has_pitch || frame_end_o !== want.frame_end) begin
        if (err_count < MaxReports)
          $display("mismatch: expected pitch %0d volume %0d has %0b end %0b, got %0d %0d %0b %0b",
                   want.pitch, want.volume, want.has_pitch, want.frame_end,
                   out_pitch_o, out_volume_o, has_pitch_o, frame_end_o);
        err_count++;
      end
    end
  endtask

  // result side: check each transaction and stall in random runs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_interval();
      if (stall_run == 0) begin
        stall_now = out_stalls_on && ($urandom_range(0, 2) == 0);
        stall_run = stall_now ? pick_run_len() : $urandom_range(1, 8);
      end
      stall_run--;
      out_stall_i <= stall_now;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_peak(logic [15:0] p, logic [15:0] v, logic last);
    int gap;
    gap = (in_gaps_on && $urandom_range(0, 2) == 0) ? pick_run_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    peak_pitch_i  <= p;
    peak_volume_i <= v;
    frame_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    merge_peak(p, v, last);
  endtask

  // drop valid, collect every result, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_intervals.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [23:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      ppim_pkg::REG_MERGE_DISTANCE: cfg_distance = data[15:0];
      ppim_pkg::REG_PITCH_MODE:     cfg_pitch_mode = data[1:0];
      ppim_pkg::REG_VOLUME_MODE:    cfg_volume_mode = data[0];
      ppim_pkg::REG_VOLUME_FLOOR:   cfg_floor = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] distance, logic [1:0] pmode, logic vmode,
                            logic [23:0] floor_level);
    put_reg(ppim_pkg::REG_MERGE_DISTANCE, {8'd0, distance});
    put_reg(ppim_pkg::REG_PITCH_MODE, {22'd0, pmode});
    put_reg(ppim_pkg::REG_VOLUME_MODE, {23'd0, vmode});
    put_reg(ppim_pkg::REG_VOLUME_FLOOR, floor_level);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config();
    logic [15:0] distance;
    logic [23:0] floor_level;
    case ($urandom_range(0, 3))
      0: distance = 16'd0;
      1: distance = 16'hFFFF;
      2: distance = 16'($urandom_range(0, 4095));
      default: distance = 16'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 4))
      0: floor_level = 24'hFF_FFFF;
      1: floor_level = 24'($urandom_range(0, 24'hFF_FFFF));
      2, 3: floor_level = 24'($urandom_range(0, 70000));
      default: floor_level = 24'd0;
    endcase
    set_config(distance, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), floor_level);
  endtask

  // one frame of mostly ascending peaks, a few out of order
  task automatic send_frame(int n);
    int p;
    int span;
    logic [15:0] v;
    span = int'(cfg_distance) * 3 / 2 + 2;
    if (span > 65535) span = 65535;
    p = $urandom_range(0, 65535);
    in_gaps_on = ($urandom_range(0, 3) != 0);
    out_stalls_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 9) == 0) p = p - int'($urandom_range(0, span));
        else p = p + int'($urandom_range(0, span));
        if (p < 0) p = 0;
        if (p > 65535) p = 65535;
      end
      case ($urandom_range(0, 7))
        0: v = 16'd0;
        1: v = 16'hFFFF;
        2: v = 16'($urandom_range(0, 255));
        default: v = 16'($urandom_range(0, 65535));
      endcase
      send_peak(p[15:0], v, i == n - 1);
    end
  endtask

  task automatic test_directed();
    // reset settings: center pitch, summed volume
    send_peak(16'd0, 16'd0, 1'b1);
    send_peak(16'hFFFF, 16'hFFFF, 1'b1);
    send_peak(16'd1000, 16'd100, 1'b0);
    send_peak(16'd1500, 16'd300, 1'b0);
    send_peak(16'd2000, 16'd200, 1'b1);
    send_peak(16'd1000, 16'd10, 1'b0);
    send_peak(16'd3000, 16'd20, 1'b1);
    send_peak(16'd5000, 16'd40, 1'b0);
    send_peak(16'd4000, 16'd50, 1'b0);
    send_peak(16'd4500, 16'd60, 1'b1);
    drain();
    // zero distance, loudest peak: ties keep the first, quiet ones drop
    set_config(16'd0, ppim_pkg::PITCH_LOUDEST, ppim_pkg::VOLUME_MAX, 24'd300);
    send_peak(16'd7000, 16'd200, 1'b0);
    send_peak(16'd7001, 16'd900, 1'b0);
    send_peak(16'd7001, 16'd900, 1'b0);
    send_peak(16'd7002, 16'd100, 1'b1);
    drain();
    // weighted mean, zero volume sum falls back to the low pitch
    set_config(16'hFFFF, ppim_pkg::PITCH_MEAN, ppim_pkg::VOLUME_SUM, 24'd0);
    send_peak(16'd100, 16'd0, 1'b0);
    send_peak(16'd60000, 16'd0, 1'b1);
    send_peak(16'd0, 16'hFFFF, 1'b0);
    send_peak(16'hFFFF, 16'hFFFF, 1'b0);
    send_peak(16'hFFFF, 16'd0, 1'b1);
    drain();
    // unused pitch mode, top floor: flushes become end markers
    set_config(16'd1536, PITCH_UNUSED, ppim_pkg::VOLUME_MAX, 24'hFF_FFFF);
    send_peak(16'd200, 16'hFFFF, 1'b1);
    send_peak(16'd10, 16'd5, 1'b0);
    send_peak(16'd20, 16'd5, 1'b1);
    drain();
  endtask

  task automatic test_saturation();
    set_config(16'hFFFF, ppim_pkg::PITCH_MEAN, ppim_pkg::VOLUME_SUM, 24'd0);
    for (int i = 0; i < 280; i++)
      send_peak(16'($urandom_range(65280, 65535)), 16'($urandom_range(65280, 65535)),
                i == 279);
    drain();
  endtask

  task automatic test_random_frames();
    int sent;
    int n;
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      sent = 0;
      while (sent < 50) begin
        n = int'($urandom_range(1, 12));
        send_frame(n);
        sent += n;
      end
      drain();
    end
  endtask

  task automatic test_noise();
    random_config();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    for (int i = 0; i < 110; i++)
      send_peak(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                $urandom_range(0, 4) == 0);
    send_peak(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1);
    drain();
  endtask

  initial begin
    cfg_distance    = ppim_pkg::RESET_MERGE_DISTANCE;
    cfg_pitch_mode  = ppim_pkg::RESET_PITCH_MODE;
    cfg_volume_mode = ppim_pkg::RESET_VOLUME_MODE;
    cfg_floor       = ppim_pkg::RESET_VOLUME_FLOOR;
    iv_open         = 1'b0;
    iv_low          = '0;
    iv_high         = '0;
    iv_loud_pitch   = '0;
    iv_loud_vol     = '0;
    iv_vol_sum      = '0;
    iv_weighted_sum = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_random_frames();
    test_noise();
    drain();
    if (err_count == 0 && pending_intervals.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ppim_pkg.sv
hw/rtl/ppim_div.sv
hw/rtl/pitch_peak_interval_merge_unit.sv
test/tb_pitch_peak_interval_merge_unit.sv
